// ===== hdl/bba_pkg.sv =====
// Constants, codes and state type for the binned bump allocator.
package bba_pkg;

    localparam int HEAP_BYTES     = 65536;
    localparam int NUM_BINS       = 16;
    localparam int GRANULE_BYTES  = 32;
    localparam int CHUNK_OVERHEAD = 32;
    localparam int USER_OFFSET    = 16;
    localparam int TOP_RESET      = 64;
    localparam int ADDR_W         = 16;
    localparam int REQ_MAX        = 65535;

    localparam int SLOT_COUNT = HEAP_BYTES / CHUNK_OVERHEAD;
    localparam int SLOT_W     = $clog2(SLOT_COUNT);
    localparam int SLOT_LSB   = $clog2(CHUNK_OVERHEAD);
    localparam int TOP_W      = $clog2(HEAP_BYTES + 1);
    localparam int SUM_W      = ((TOP_W > 17) ? TOP_W : 17) + 1;
    localparam int GRAN_W     = $clog2((REQ_MAX + GRANULE_BYTES - 1) / GRANULE_BYTES + 1);
    localparam int BIN_W      = (NUM_BINS > 1) ? $clog2(NUM_BINS) : 1;

    localparam logic OP_ALLOC = 1'b0;
    localparam logic OP_FREE  = 1'b1;

    typedef enum logic [5:0] {
        S_INIT0 = 6'b000001,
        S_INIT1 = 6'b000010,
        S_IDLE  = 6'b000100,
        S_FREE  = 6'b001000,
        S_POP   = 6'b010000,
        S_MARK  = 6'b100000
    } t_state;

endpackage

// ===== hdl/binned_bump_allocator_top.sv =====
// Binned bump heap allocator: size memory, free-link memory and bin head registers.
//
//   channel   direction  handshake                  word
//   in        to block   i_in_valid / o_in_ready    i_operation, i_request_bytes, i_user_address
//   out       from block o_out_valid / i_out_ready  o_result_address, o_out_of_memory, o_from_bin
//
// A null or misplaced free and an out-of-memory allocate answer in idle; a free and a bin
// pop read the size or link memory in idle and answer in S_FREE or S_POP; a bump allocate
// answers in idle and S_MARK zeroes the size at the new top. After reset the block writes
// the reserved chunk size and top marker. One word is in flight at a time; a result waiting
// in the output register does not block the next word if it is taken in the same cycle.
module binned_bump_allocator_top (
    input  logic                        i_clk,
    input  logic                        i_rst_n,
    input  logic                        i_in_valid,
    output logic                        o_in_ready,
    input  logic                        i_operation,
    input  logic [bba_pkg::ADDR_W-1:0]  i_request_bytes,
    input  logic [bba_pkg::ADDR_W-1:0]  i_user_address,
    output logic                        o_out_valid,
    input  logic                        i_out_ready,
    output logic [bba_pkg::ADDR_W-1:0]  o_result_address,
    output logic                        o_out_of_memory,
    output logic                        o_from_bin
);

    localparam int SLOT_W = bba_pkg::SLOT_W;
    localparam int SUM_W  = bba_pkg::SUM_W;
    localparam int GRAN_W = bba_pkg::GRAN_W;
    localparam int BIN_W  = bba_pkg::BIN_W;
    localparam int TOP_W  = bba_pkg::TOP_W;
    localparam int ADDR_W = bba_pkg::ADDR_W;
    localparam int NBINS  = bba_pkg::NUM_BINS;
    localparam int LSB    = bba_pkg::SLOT_LSB;

    // Memories
    logic [GRAN_W-1:0] mem_gran [bba_pkg::SLOT_COUNT];
    logic [SLOT_W-1:0] mem_link [bba_pkg::SLOT_COUNT];
    logic [GRAN_W-1:0] r_gran_rd;
    logic [SLOT_W-1:0] r_link_rd;

    logic              gran_we;
    logic [SLOT_W-1:0] gran_wa;
    logic [GRAN_W-1:0] gran_wd;
    logic              link_we;
    logic [SLOT_W-1:0] link_wa;
    logic [SLOT_W-1:0] link_wd;

    // Control and payload registers
    bba_pkg::t_state   r_state, n_state;
    logic [TOP_W-1:0]  r_top, n_top;
    logic [NBINS-1:0]  r_bin_valid, n_bin_valid;
    logic [SLOT_W-1:0] r_head_slot [NBINS];
    logic [SLOT_W-1:0] n_head_slot [NBINS];
    logic [SLOT_W-1:0] r_slot, n_slot;
    logic [SUM_W-1:0]  r_chunk, n_chunk;
    logic [BIN_W-1:0]  r_bin, n_bin;
    logic              r_out_valid, n_out_valid;
    logic [ADDR_W-1:0] r_res, n_res;
    logic              r_oom, n_oom;
    logic              r_binned, n_binned;

    // Input decode
    logic              in_acc;
    logic              out_free;
    logic [SUM_W-1:0]  req_round;
    logic [GRAN_W-1:0] req_gran;
    logic [GRAN_W-1:0] req_gran_m1;
    logic              req_has_bin;
    logic [BIN_W-1:0]  req_bin;
    logic              req_hit;
    logic [SUM_W-1:0]  stride;
    logic [SUM_W-1:0]  top_ext;
    logic [SUM_W-1:0]  bump_end;
    logic              bump_fits;
    logic [SUM_W-1:0]  bump_res;
    logic [SLOT_W-1:0] top_slot;
    logic [SUM_W-1:0]  addr_ext;
    logic [SUM_W-1:0]  free_chunk;
    logic              free_ok;
    logic [SLOT_W-1:0] free_slot;
    logic [SUM_W-1:0]  free_end;
    logic [GRAN_W-1:0] rd_gran_m1;
    logic              rd_has_bin;
    logic [BIN_W-1:0]  rd_bin;
    logic [SUM_W-1:0]  pop_res;
    logic              top_in_heap;

    assign out_free   = !r_out_valid || i_out_ready;
    assign o_in_ready = (r_state == bba_pkg::S_IDLE) && out_free;
    assign in_acc     = i_in_valid && o_in_ready;

    assign req_round   = SUM_W'(i_request_bytes) + SUM_W'(bba_pkg::GRANULE_BYTES - 1);
    assign req_gran    = GRAN_W'(req_round / bba_pkg::GRANULE_BYTES);
    assign req_gran_m1 = req_gran - GRAN_W'(1);
    assign req_has_bin = (req_gran != '0) && (req_gran <= GRAN_W'(NBINS));
    assign req_bin     = req_gran_m1[BIN_W-1:0];
    assign req_hit     = req_has_bin && r_bin_valid[req_bin];

    assign stride      = SUM_W'(req_gran) * SUM_W'(bba_pkg::GRANULE_BYTES)
                       + SUM_W'(bba_pkg::CHUNK_OVERHEAD);
    assign top_ext     = SUM_W'(r_top);
    assign bump_end    = top_ext + stride;
    assign bump_fits   = bump_end <= SUM_W'(bba_pkg::HEAP_BYTES);
    assign bump_res    = top_ext + SUM_W'(bba_pkg::USER_OFFSET);
    assign top_slot    = top_ext[LSB +: SLOT_W];
    assign top_in_heap = top_ext < SUM_W'(bba_pkg::HEAP_BYTES);

    // Null, low, misaligned and out-of-heap frees are dropped at accept
    assign addr_ext   = SUM_W'(i_user_address);
    assign free_chunk = addr_ext - SUM_W'(bba_pkg::USER_OFFSET);
    assign free_ok    = (i_user_address >= ADDR_W'(bba_pkg::USER_OFFSET))
                     && (free_chunk[LSB-1:0] == '0)
                     && (free_chunk < SUM_W'(bba_pkg::HEAP_BYTES));
    assign free_slot  = free_chunk[LSB +: SLOT_W];

    assign free_end   = r_chunk + SUM_W'(r_gran_rd) * SUM_W'(bba_pkg::GRANULE_BYTES)
                      + SUM_W'(bba_pkg::CHUNK_OVERHEAD);
    assign rd_gran_m1 = r_gran_rd - GRAN_W'(1);
    assign rd_has_bin = (r_gran_rd != '0) && (r_gran_rd <= GRAN_W'(NBINS));
    assign rd_bin     = rd_gran_m1[BIN_W-1:0];

    assign pop_res    = (SUM_W'(r_slot) << LSB) + SUM_W'(bba_pkg::USER_OFFSET);

    always_comb begin
        n_state     = r_state;
        n_top       = r_top;
        n_bin_valid = r_bin_valid;
        n_head_slot = r_head_slot;
        n_slot      = r_slot;
        n_chunk     = r_chunk;
        n_bin       = r_bin;
        n_out_valid = r_out_valid && !i_out_ready;
        n_res       = r_res;
        n_oom       = r_oom;
        n_binned    = r_binned;
        gran_we     = 1'b0;
        gran_wa     = top_slot;
        gran_wd     = '0;
        link_we     = 1'b0;
        link_wa     = r_slot;
        link_wd     = r_slot;

        case (r_state)
            bba_pkg::S_INIT0: begin
                // reserve chunk 0 as one granule
                gran_we = 1'b1;
                gran_wa = '0;
                gran_wd = GRAN_W'(1);
                n_state = bba_pkg::S_INIT1;
            end
            bba_pkg::S_INIT1: begin
                gran_we = 1'b1;
                gran_wa = SLOT_W'(bba_pkg::TOP_RESET / bba_pkg::CHUNK_OVERHEAD);
                gran_wd = '0;
                n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_IDLE: begin
                if (in_acc) begin
                    if (i_operation == bba_pkg::OP_FREE) begin
                        if (free_ok) begin
                            n_slot  = free_slot;
                            n_chunk = free_chunk;
                            n_state = bba_pkg::S_FREE;
                        end else begin
                            n_out_valid = 1'b1;
                            n_res       = '0;
                            n_oom       = 1'b0;
                            n_binned    = 1'b0;
                        end
                    end else if (req_hit) begin
                        n_slot  = r_head_slot[req_bin];
                        n_bin   = req_bin;
                        n_state = bba_pkg::S_POP;
                    end else if (bump_fits) begin
                        gran_we     = 1'b1;
                        gran_wa     = top_slot;
                        gran_wd     = req_gran;
                        n_top       = bump_end[TOP_W-1:0];
                        n_out_valid = 1'b1;
                        n_res       = bump_res[ADDR_W-1:0];
                        n_oom       = 1'b0;
                        n_binned    = 1'b0;
                        n_state     = bba_pkg::S_MARK;
                    end else begin
                        n_out_valid = 1'b1;
                        n_res       = '0;
                        n_oom       = 1'b1;
                        n_binned    = 1'b0;
                    end
                end
            end
            bba_pkg::S_MARK: begin
                // zero the size at the new top
                gran_we = top_in_heap;
                gran_wa = top_slot;
                gran_wd = '0;
                n_state = bba_pkg::S_IDLE;
            end
            bba_pkg::S_FREE: begin
                if (free_end == top_ext) begin
                    n_top   = r_chunk[TOP_W-1:0];
                    gran_we = 1'b1;
                    gran_wa = r_slot;
                    gran_wd = '0;
                end else if (rd_has_bin) begin
                    // push: old head below, or self-link for the bottom
                    link_we             = 1'b1;
                    link_wa             = r_slot;
                    link_wd             = r_bin_valid[rd_bin] ? r_head_slot[rd_bin] : r_slot;
                    n_head_slot[rd_bin] = r_slot;
                    n_bin_valid[rd_bin] = 1'b1;
                end
                n_out_valid = 1'b1;
                n_res       = '0;
                n_oom       = 1'b0;
                n_binned    = 1'b0;
                n_state     = bba_pkg::S_IDLE;
            end
            bba_pkg::S_POP: begin
                if (r_link_rd == r_slot) begin
                    n_bin_valid[r_bin] = 1'b0;
                end else begin
                    n_head_slot[r_bin] = r_link_rd;
                end
                n_out_valid = 1'b1;
                n_res       = pop_res[ADDR_W-1:0];
                n_oom       = 1'b0;
                n_binned    = 1'b1;
                n_state     = bba_pkg::S_IDLE;
            end
            default: begin
                n_state = bba_pkg::S_IDLE;
            end
        endcase
    end

    // Reads are issued only from idle; every write lands before the next accept,
    // so no forwarding is needed.
    always_ff @(posedge i_clk) begin
        if (gran_we) begin
            mem_gran[gran_wa] <= gran_wd;
        end
        if (r_state == bba_pkg::S_IDLE) begin
            r_gran_rd <= mem_gran[free_slot];
        end
    end

    always_ff @(posedge i_clk) begin
        if (link_we) begin
            mem_link[link_wa] <= link_wd;
        end
        if (r_state == bba_pkg::S_IDLE) begin
            r_link_rd <= mem_link[r_head_slot[req_bin]];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= bba_pkg::S_INIT0;
            r_top       <= TOP_W'(bba_pkg::TOP_RESET);
            r_bin_valid <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_top       <= n_top;
            r_bin_valid <= n_bin_valid;
            r_out_valid <= n_out_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        r_head_slot <= n_head_slot;
        r_slot      <= n_slot;
        r_chunk     <= n_chunk;
        r_bin       <= n_bin;
        r_res       <= n_res;
        r_oom       <= n_oom;
        r_binned    <= n_binned;
    end

    assign o_out_valid      = r_out_valid;
    assign o_result_address = r_res;
    assign o_out_of_memory  = r_oom;
    assign o_from_bin       = r_binned;

    a_top_in_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        top_ext <= SUM_W'(bba_pkg::HEAP_BYTES))
        else $error("top offset beyond heap");

    a_work_after_accept: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        in_acc && (i_operation == bba_pkg::OP_FREE) && free_ok |=> r_state == bba_pkg::S_FREE)
        else $error("valid free did not enter size lookup");

    a_oom_is_null: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_out_valid && r_oom |-> (r_res == '0) && !r_binned)
        else $error("out-of-memory result carries an address");

    a_pop_from_valid_bin: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == bba_pkg::S_POP |-> r_bin_valid[r_bin])
        else $error("pop from an empty bin");

    a_single_in_flight: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == bba_pkg::S_FREE || r_state == bba_pkg::S_POP) |-> !o_in_ready)
        else $error("input taken while a word is in flight");

endmodule

// ===== tb/tb_binned_bump_allocator_top.sv =====
// Self-checking testbench for the binned bump heap allocator.
`timescale 1ns / 100ps

module tb_binned_bump_allocator_top;

    localparam int ADDR_W         = bba_pkg::ADDR_W;
    localparam int TOP_W          = bba_pkg::TOP_W;
    localparam int SLOT_W         = bba_pkg::SLOT_W;
    localparam int GRAN_W         = bba_pkg::GRAN_W;
    localparam int NUM_BINS       = bba_pkg::NUM_BINS;
    localparam int SLOT_COUNT     = bba_pkg::SLOT_COUNT;
    localparam int HEAP_BYTES     = bba_pkg::HEAP_BYTES;
    localparam int CHUNK_OVERHEAD = bba_pkg::CHUNK_OVERHEAD;
    localparam int USER_OFFSET    = bba_pkg::USER_OFFSET;
    localparam int GRANULE_BYTES  = bba_pkg::GRANULE_BYTES;
    localparam int TOP_RESET      = bba_pkg::TOP_RESET;

    localparam int RANDOM_WORDS = 400;
    localparam int CYCLE_LIMIT  = 300000;
    localparam int DRAIN_CYCLES = 20;
    localparam int HOLD_CYCLES  = 300;
    localparam int FREED_KEEP   = 64;

    typedef struct packed {
        logic [ADDR_W-1:0] addr;
        logic              oom;
        logic              from_bin;
    } t_heap_result;

    typedef struct packed {
        logic              op;
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] addr;
        logic              typed;
        t_heap_result      res;
    } t_heap_row;

    logic              i_clk = 1'b0;
    logic              i_rst_n = 1'b0;
    logic              i_in_valid = 1'b0;
    logic              o_in_ready;
    logic              i_operation = bba_pkg::OP_ALLOC;
    logic [ADDR_W-1:0] i_request_bytes = '0;
    logic [ADDR_W-1:0] i_user_address = '0;
    logic              o_out_valid;
    logic              i_out_ready = 1'b0;
    logic [ADDR_W-1:0] o_result_address;
    logic              o_out_of_memory;
    logic              o_from_bin;

    // allocator image
    logic [TOP_W-1:0]  heap_top;
    logic              bin_live  [NUM_BINS];
    logic [SLOT_W-1:0] bin_top   [NUM_BINS];
    logic [SLOT_W-1:0] slot_link [SLOT_COUNT];
    logic [GRAN_W-1:0] slot_gran [SLOT_COUNT];
    bit                slot_known [SLOT_COUNT];

    t_heap_result      heap_results_q [$];
    logic [ADDR_W-1:0] live_user_q [$];
    logic [ADDR_W-1:0] freed_user_q [$];

    int error_count   = 0;
    int cycle_count   = 0;
    bit idle_on       = 1'b1;
    bit hold_off_req  = 1'b0;

    // Rows with typed results come straight from the allocation rules; the rest
    // go through the predictor. Heap top starts at 64.
    t_heap_row heap_rows [27] = '{
        '{bba_pkg::OP_ALLOC, 16'd0,     16'd0,     1'b1, '{16'd80,  1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd1,     16'd0,     1'b1, '{16'd112, 1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd512,   16'd0,     1'b1, '{16'd176, 1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd513,   16'd0,     1'b1, '{16'd720, 1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd112,   1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd176,   1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd0,     1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd8,     1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd81,    1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd16,    1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd720,   1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd32,    16'd0,     1'b1, '{16'd16,  1'b0, 1'b1}},
        '{bba_pkg::OP_ALLOC, 16'd17,    16'd0,     1'b1, '{16'd112, 1'b0, 1'b1}},
        '{bba_pkg::OP_ALLOC, 16'd500,   16'd0,     1'b1, '{16'd176, 1'b0, 1'b1}},
        '{bba_pkg::OP_ALLOC, 16'hFFFF,  16'hFFFF,  1'b1, '{16'd0,   1'b1, 1'b0}},
        '{bba_pkg::OP_FREE,  16'hFFFF,  16'hFFFF,  1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd80,    1'b1, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd33,    16'd0,     1'b1, '{16'd720, 1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd544,   16'd0,     1'b0, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd816,   1'b0, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd720,   1'b0, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd64000, 16'd0,     1'b0, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd1024,  16'd0,     1'b1, '{16'd0,   1'b1, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd768,   16'd0,     1'b0, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_ALLOC, 16'd0,     16'd0,     1'b1, '{16'd0,   1'b1, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd64752, 1'b0, '{16'd0,   1'b0, 1'b0}},
        '{bba_pkg::OP_FREE,  16'd0,     16'd720,   1'b0, '{16'd0,   1'b0, 1'b0}}
    };

    binned_bump_allocator_top uut (
        .i_clk            (i_clk),
        .i_rst_n          (i_rst_n),
        .i_in_valid       (i_in_valid),
        .o_in_ready       (o_in_ready),
        .i_operation      (i_operation),
        .i_request_bytes  (i_request_bytes),
        .i_user_address   (i_user_address),
        .o_out_valid      (o_out_valid),
        .i_out_ready      (i_out_ready),
        .o_result_address (o_result_address),
        .o_out_of_memory  (o_out_of_memory),
        .o_from_bin       (o_from_bin)
    );

    always begin
        #4 i_clk = 1'b1;
        #4 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT) begin
            $display("tb_binned_bump_allocator_top: done, errors");
            $finish;
        end
    end

    // Zero the size entry of the slot at the top, unless the heap is full.
    function automatic void mark_heap_top();
        if (heap_top < HEAP_BYTES) begin
            slot_gran[heap_top / CHUNK_OVERHEAD]  = '0;
            slot_known[heap_top / CHUNK_OVERHEAD] = 1'b1;
        end
    endfunction

    function automatic t_heap_result run_heap_request(input logic op,
                                                      input logic [ADDR_W-1:0] req,
                                                      input logic [ADDR_W-1:0] addr);
        t_heap_result res;
        int chunk;
        int slot;
        int gran;
        int nxt;
        int stride;
        res = '0;
        if (op == bba_pkg::OP_FREE) begin
            if (addr >= USER_OFFSET && ((int'(addr) - USER_OFFSET) % CHUNK_OVERHEAD) == 0) begin
                chunk = int'(addr) - USER_OFFSET;
                slot  = chunk / CHUNK_OVERHEAD;
                gran  = int'(slot_gran[slot]);
                if (chunk + gran * GRANULE_BYTES + CHUNK_OVERHEAD == int'(heap_top)) begin
                    heap_top = TOP_W'(chunk);
                    mark_heap_top();
                end else if (gran >= 1 && gran <= NUM_BINS) begin
                    slot_link[slot]   = bin_live[gran-1] ? bin_top[gran-1] : SLOT_W'(slot);
                    bin_top[gran-1]   = SLOT_W'(slot);
                    bin_live[gran-1]  = 1'b1;
                end
            end
        end else begin
            gran = (int'(req) + GRANULE_BYTES - 1) / GRANULE_BYTES;
            if (gran >= 1 && gran <= NUM_BINS && bin_live[gran-1]) begin
                slot = int'(bin_top[gran-1]);
                nxt  = int'(slot_link[slot]);
                if (nxt == slot)
                    bin_live[gran-1] = 1'b0;
                else
                    bin_top[gran-1] = SLOT_W'(nxt);
                res.addr     = ADDR_W'(slot * CHUNK_OVERHEAD + USER_OFFSET);
                res.from_bin = 1'b1;
            end else begin
                stride = gran * GRANULE_BYTES + CHUNK_OVERHEAD;
                if (int'(heap_top) + stride > HEAP_BYTES) begin
                    res.oom = 1'b1;
                end else begin
                    slot_gran[heap_top / CHUNK_OVERHEAD]  = GRAN_W'(gran);
                    slot_known[heap_top / CHUNK_OVERHEAD] = 1'b1;
                    res.addr = ADDR_W'(int'(heap_top) + USER_OFFSET);
                    heap_top = TOP_W'(int'(heap_top) + stride);
                    mark_heap_top();
                end
            end
        end
        return res;
    endfunction

    // Offer one word, hold it until taken, then log what the heap should answer.
    task automatic send_heap_word(input logic op, input logic [ADDR_W-1:0] req,
                                  input logic [ADDR_W-1:0] addr, input logic typed,
                                  input t_heap_result typed_res);
        int gap;
        t_heap_result res;
        gap = idle_on ? $urandom_range(0, 14) : 0;
        if (gap > 0) begin
            i_in_valid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
        i_in_valid      <= 1'b1;
        i_operation     <= op;
        i_request_bytes <= req;
        i_user_address  <= addr;
        do @(posedge i_clk); while (o_in_ready !== 1'b1);
        res = run_heap_request(op, req, addr);
        if (op == bba_pkg::OP_ALLOC && !res.oom)
            live_user_q.push_back(res.addr);
        heap_results_q.push_back(typed ? typed_res : res);
    endtask

    task automatic pick_heap_word(output logic op, output logic [ADDR_W-1:0] req,
                                  output logic [ADDR_W-1:0] addr);
        int pick;
        int kind;
        int idx;
        pick = $urandom_range(0, 99);
        req  = ADDR_W'($urandom);
        addr = ADDR_W'($urandom);
        if (pick < 52 || (live_user_q.size() == 0 && pick < 85)) begin
            op   = bba_pkg::OP_ALLOC;
            kind = $urandom_range(0, 99);
            if (kind < 45)      req = ADDR_W'($urandom_range(1, 512));
            else if (kind < 53) req = ADDR_W'(GRANULE_BYTES * $urandom_range(1, NUM_BINS));
            else if (kind < 58) req = '0;
            else if (kind < 80) req = ADDR_W'($urandom_range(513, 4096));
            else if (kind < 95) req = ADDR_W'($urandom_range(4097, 24000));
        end else if (pick < 88 && live_user_q.size() > 0) begin
            // favor the newest chunk so the top moves back often
            op  = bba_pkg::OP_FREE;
            idx = $urandom_range(0, 1) ? live_user_q.size() - 1
                                       : $urandom_range(0, live_user_q.size() - 1);
            addr = live_user_q[idx];
            live_user_q.delete(idx);
            freed_user_q.push_back(addr);
            if (freed_user_q.size() > FREED_KEEP)
                void'(freed_user_q.pop_front());
        end else begin
            op = bba_pkg::OP_FREE;
            case ($urandom_range(0, 3))
                0: addr = '0;
                1: addr = ADDR_W'($urandom_range(1, USER_OFFSET - 1));
                2: addr = (freed_user_q.size() > 0)
                          ? freed_user_q[$urandom_range(0, freed_user_q.size() - 1)] : '0;
                default: begin
                    // keep off chunks whose size entry was never written
                    if (addr >= USER_OFFSET && ((int'(addr) - USER_OFFSET) % CHUNK_OVERHEAD) == 0
                        && !slot_known[(int'(addr) - USER_OFFSET) / CHUNK_OVERHEAD])
                        addr[0] = ~addr[0];
                end
            endcase
        end
    endtask

    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && i_out_ready) begin
            if (heap_results_q.size() == 0) begin
                $error("unexpected word: result_address %0d out_of_memory %0b from_bin %0b",
                       o_result_address, o_out_of_memory, o_from_bin);
                error_count++;
            end else begin
                if (o_result_address !== heap_results_q[0].addr) begin
                    $error("result_address expected %0d actual %0d",
                           heap_results_q[0].addr, o_result_address);
                    error_count++;
                end
                if (o_out_of_memory !== heap_results_q[0].oom) begin
                    $error("out_of_memory expected %0b actual %0b",
                           heap_results_q[0].oom, o_out_of_memory);
                    error_count++;
                end
                if (o_from_bin !== heap_results_q[0].from_bin) begin
                    $error("from_bin expected %0b actual %0b",
                           heap_results_q[0].from_bin, o_from_bin);
                    error_count++;
                end
                void'(heap_results_q.pop_front());
            end
        end
    end

    initial begin
        int stall;
        wait (i_rst_n === 1'b1);
        forever begin
            stall = idle_on ? $urandom_range(0, 14) : 0;
            if (hold_off_req) begin
                stall        = HOLD_CYCLES;
                hold_off_req = 1'b0;
            end
            if (stall > 0) begin
                i_out_ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            i_out_ready <= 1'b1;
            do @(posedge i_clk); while (o_out_valid !== 1'b1);
        end
    end

    initial begin
        logic              op;
        logic [ADDR_W-1:0] req;
        logic [ADDR_W-1:0] addr;
        for (int b = 0; b < NUM_BINS; b++) begin
            bin_live[b] = 1'b0;
            bin_top[b]  = '0;
        end
        for (int s = 0; s < SLOT_COUNT; s++)
            slot_known[s] = 1'b0;
        slot_gran[0]  = GRAN_W'(1);
        slot_known[0] = 1'b1;
        heap_top      = TOP_W'(TOP_RESET);
        mark_heap_top();

        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        foreach (heap_rows[r])
            send_heap_word(heap_rows[r].op, heap_rows[r].req, heap_rows[r].addr,
                           heap_rows[r].typed, heap_rows[r].res);

        for (int n = 0; n < RANDOM_WORDS; n++) begin
            if (n == 150)
                hold_off_req = 1'b1;
            if (n == 250) begin
                // drop valid so the last word is not taken twice while waiting
                i_in_valid <= 1'b0;
                while (heap_results_q.size() != 0) @(posedge i_clk);
            end
            idle_on = !(n >= 300 && n < 360);
            pick_heap_word(op, req, addr);
            send_heap_word(op, req, addr, 1'b0, '0);
        end
        i_in_valid <= 1'b0;

        while (heap_results_q.size() != 0) @(posedge i_clk);
        repeat (DRAIN_CYCLES) @(posedge i_clk);
        if (error_count == 0)
            $display("tb_binned_bump_allocator_top: done, clean");
        else
            $display("tb_binned_bump_allocator_top: done, errors");
        $finish;
    end

endmodule
